// File: sv/rlas_pkg.sv
// Shared types and constants for the redundant link alive supervisor.
// Has no dependencies. The front, back and top level import it.
package rlas_pkg;

  localparam int NUM_MON = 4;
  localparam int MON_W   = 2;

  // Operation codes.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Frame kinds. Any other code is an unrelated identifier.
  localparam logic [1:0] KIND_CONTROL = 2'd0;
  localparam logic [1:0] KIND_SERVICE = 2'd1;

  // Monitor indices: kind in the upper bit, bus in the lower bit.
  localparam logic [MON_W-1:0] MON_CTRL_MAIN   = 2'd0;
  localparam logic [MON_W-1:0] MON_CTRL_BACKUP = 2'd1;

  // Control source codes.
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_MAIN   = 2'd1;
  localparam logic [1:0] SRC_BACKUP = 2'd2;

  // Alive status codes.
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_SEQ   = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_GAP   = 3'd4;

  // Configuration register indices.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_STALE_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_LEN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SERVICE_LEN   = 2'd2;

  localparam logic [15:0] RST_STALE_TIMEOUT = 16'd100;
  localparam logic [6:0]  RST_CONTROL_LEN   = 7'd8;
  localparam logic [6:0]  RST_SERVICE_LEN   = 7'd8;

  localparam logic [3:0]  ALIVE_MASK = 4'hF;
  localparam logic [15:0] TALLY_MAX  = 16'hFFFF;

  typedef struct packed {
    logic       operation;
    logic [31:0] now_ms;
    logic [1:0] bus;
    logic [1:0] frame_kind;
    logic       is_fd;
    logic       rate_switched;
    logic       extended_id;
    logic [6:0] frame_length;
    logic       decode_ok;
    logic [3:0] alive_value;
  } item_t;

  typedef struct packed {
    logic        recognized;
    logic        accepted;
    logic        discontinuity;
    logic        service_ready;
    logic [2:0]  alive_status;
    logic [1:0]  active_source;
    logic [15:0] switch_count;
    logic        authority_fresh;
    logic [15:0] dropped_total;
    logic [15:0] discontinuity_total;
  } result_t;

  typedef struct packed {
    logic [15:0] stale_timeout_ms;
    logic [6:0]  control_frame_length;
    logic [6:0]  service_frame_length;
  } cfg_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    logic             tick;
    logic [31:0]      now_ms;
    logic             recognized;
    logic             observe;
    logic [MON_W-1:0] mon;
    logic             service;
    logic [3:0]       alive;
  } cmd_t;

endpackage

// File: sv/rlas_front.sv
// Front end: accepts items and classifies them into back-end commands.
// Depends on rlas_pkg.
module rlas_front (
  input  rlas_pkg::item_t item,
  input  logic            item_valid,
  input  rlas_pkg::cfg_t  cfg,
  input  logic            queue_full,
  output logic            item_stall,
  output logic            push,
  output rlas_pkg::cmd_t  cmd
);
  import rlas_pkg::*;

  logic       known;
  logic [6:0] need_len;
  logic       frame_ok;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  // Known bus and a control or service identifier.
  assign known    = (item.operation == OP_FRAME) && !item.bus[1] && !item.frame_kind[1];
  assign need_len = (item.frame_kind == KIND_SERVICE) ? cfg.service_frame_length
                                                      : cfg.control_frame_length;
  assign frame_ok = item.is_fd && item.rate_switched && !item.extended_id &&
                    (item.frame_length == need_len) && item.decode_ok;

  always_comb begin
    cmd.tick       = (item.operation == OP_TICK);
    cmd.now_ms     = item.now_ms;
    cmd.recognized = known;
    cmd.observe    = known && frame_ok;
    cmd.mon        = {item.frame_kind[0], item.bus[0]};
    cmd.service    = (item.frame_kind == KIND_SERVICE);
    cmd.alive      = item.alive_value & ALIVE_MASK;
  end

endmodule

// File: sv/rlas_queue.sv
// Short first-in first-out queue of classified commands.
// Generic; no package dependency.
module rlas_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_data = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: sv/rlas_back.sv
// Back end: alive monitors, source selection and the result register.
// Depends on rlas_pkg.
module rlas_back (
  input  logic              clk,
  input  logic              rst,
  input  rlas_pkg::cfg_t    cfg,
  input  rlas_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  input  logic              result_stall,
  output logic              pop,
  output logic              result_valid,
  output rlas_pkg::result_t result
);
  import rlas_pkg::*;

  logic        started      [NUM_MON];
  logic [3:0]  last_alive   [NUM_MON];
  logic [31:0] last_time    [NUM_MON];
  logic [15:0] progress     [NUM_MON];
  logic [15:0] disc_tally   [NUM_MON];
  logic [15:0] drop_tally   [NUM_MON];

  logic [1:0]  source_select;
  logic [15:0] source_switches;
  logic        recovery_active;
  logic [31:0] recovery_time;
  logic [15:0] recovery_tally;

  logic [1:0]  source_next;
  logic [15:0] switches_next;
  logic        recovery_next;
  logic        recovery_load;

  logic        main_current;
  logic        backup_current;
  logic [31:0] main_age;
  logic [31:0] backup_age;
  logic [31:0] hold_age;
  logic [31:0] timeout_ext;

  logic [3:0]  delta;
  logic        is_first;
  logic        is_dup;
  logic        is_gap;
  logic [2:0]  status;
  logic [3:0]  drop_inc;
  logic        disc_inc;
  logic [15:0] disc_new;
  logic [15:0] drop_new;
  logic        progressed;
  logic [1:0]  report_src;
  logic        fresh_main_post;
  logic        fresh_backup_post;
  result_t     result_next;

  function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [3:0] inc);
    logic [16:0] s;
    s = {1'b0, v} + {13'b0, inc};
    return s[16] ? TALLY_MAX : s[15:0];
  endfunction

  assign pop = cmd_valid && (!result_valid || !result_stall);

  // Freshness of the two control monitors before this command.
  assign timeout_ext    = {16'b0, cfg.stale_timeout_ms};
  assign main_age       = cmd.now_ms - last_time[MON_CTRL_MAIN];
  assign backup_age     = cmd.now_ms - last_time[MON_CTRL_BACKUP];
  assign hold_age       = cmd.now_ms - recovery_time;
  assign main_current   = started[MON_CTRL_MAIN] && (main_age <= timeout_ext);
  assign backup_current = started[MON_CTRL_BACKUP] && (backup_age <= timeout_ext);

  // Alive classification of the addressed monitor.
  always_comb begin
    delta    = cmd.alive - last_alive[cmd.mon];
    is_first = !started[cmd.mon];
    is_dup   = !is_first && (delta == 4'd0);
    is_gap   = !is_first && (delta != 4'd0) && (delta != 4'd1);
    if (is_first) begin
      status = ST_FIRST;
    end else if (is_dup) begin
      status = ST_DUP;
    end else if (is_gap) begin
      status = ST_GAP;
    end else begin
      status = ST_SEQ;
    end
    disc_inc   = is_dup || is_gap;
    drop_inc   = is_dup ? 4'd1 : (is_gap ? delta - 4'd1 : 4'd0);
    disc_new   = sat_add(disc_tally[cmd.mon], {3'b0, disc_inc});
    drop_new   = sat_add(drop_tally[cmd.mon], drop_inc);
    progressed = cmd.observe && !is_dup;
  end

  // Source re-evaluation for a tick.
  always_comb begin
    source_next   = source_select;
    recovery_next = recovery_active;
    recovery_load = 1'b0;
    case (source_select)
      SRC_NONE: begin
        if (main_current) begin
          source_next = SRC_MAIN;
        end else if (backup_current) begin
          source_next = SRC_BACKUP;
        end
        recovery_next = 1'b0;
      end
      SRC_MAIN: begin
        if (!main_current) begin
          source_next = backup_current ? SRC_BACKUP : SRC_NONE;
        end
        recovery_next = 1'b0;
      end
      SRC_BACKUP: begin
        if (!main_current) begin
          recovery_next = 1'b0;
          if (!backup_current) begin
            source_next = SRC_NONE;
          end
        end else if (!recovery_active) begin
          // A freshly opened hold can never complete in the same tick.
          recovery_next = 1'b1;
          recovery_load = 1'b1;
        end else if ((hold_age >= timeout_ext) &&
                     (progress[MON_CTRL_MAIN] != recovery_tally)) begin
          source_next   = SRC_MAIN;
          recovery_next = 1'b0;
        end
      end
      default: begin
        source_next = source_select;
      end
    endcase
    switches_next = (source_next != source_select) ? source_switches + 1'b1
                                                  : source_switches;
  end

  // Result as seen after the command is applied.
  always_comb begin
    report_src        = cmd.tick ? source_next : source_select;
    fresh_main_post   = main_current || (progressed && (cmd.mon == MON_CTRL_MAIN));
    fresh_backup_post = backup_current || (progressed && (cmd.mon == MON_CTRL_BACKUP));

    result_next.recognized        = cmd.recognized;
    result_next.accepted          = progressed;
    result_next.discontinuity     = cmd.observe && disc_inc;
    result_next.service_ready     = progressed && cmd.service;
    result_next.alive_status      = cmd.observe ? status : ST_NONE;
    result_next.active_source     = report_src;
    result_next.switch_count      = cmd.tick ? switches_next : source_switches;
    if (report_src == SRC_MAIN) begin
      result_next.authority_fresh = fresh_main_post;
    end else if (report_src == SRC_BACKUP) begin
      result_next.authority_fresh = fresh_backup_post;
    end else begin
      result_next.authority_fresh = 1'b0;
    end
    result_next.dropped_total       = cmd.observe ? drop_new : 16'd0;
    result_next.discontinuity_total = cmd.observe ? disc_new : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MON; i++) begin
        started[i]    <= 1'b0;
        last_alive[i] <= 4'd0;
        last_time[i]  <= 32'd0;
        progress[i]   <= 16'd0;
        disc_tally[i] <= 16'd0;
        drop_tally[i] <= 16'd0;
      end
      source_select   <= SRC_NONE;
      source_switches <= 16'd0;
      recovery_active <= 1'b0;
      recovery_time   <= 32'd0;
      recovery_tally  <= 16'd0;
      result_valid    <= 1'b0;
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop && cmd.observe) begin
        disc_tally[cmd.mon] <= disc_new;
        drop_tally[cmd.mon] <= drop_new;
        if (is_first) begin
          started[cmd.mon]    <= 1'b1;
          last_alive[cmd.mon] <= cmd.alive;
          last_time[cmd.mon]  <= cmd.now_ms;
          progress[cmd.mon]   <= 16'd1;
        end else if (!is_dup) begin
          last_alive[cmd.mon] <= cmd.alive;
          last_time[cmd.mon]  <= cmd.now_ms;
          progress[cmd.mon]   <= progress[cmd.mon] + 1'b1;
        end
      end
      if (pop && cmd.tick) begin
        source_select   <= source_next;
        source_switches <= switches_next;
        recovery_active <= recovery_next;
        if (recovery_load) begin
          recovery_time  <= cmd.now_ms;
          recovery_tally <= progress[MON_CTRL_MAIN];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

// File: sv/redundant_link_alive_supervisor.sv
// Top level of the redundant link alive supervisor: configuration registers,
// front end, command queue and back end. Depends on rlas_pkg and all rlas_ modules.
//
// Supervises control and service-request traffic on a main and a backup bus.
// Each item is either a received frame or a re-evaluation tick; every item
// yields exactly one result transfer. Frames are checked (FD, bit rate switch,
// standard identifier, exact length, decode success) in the front end, then a
// short queue hands them to the back end, which keeps four alive-counter
// monitors (control and service, per bus), classifies each valid frame as
// first, in sequence, duplicate or gap and keeps saturating tallies. Ticks pick
// the control authority from monitor freshness and return to main only after a
// recovery hold in which main made progress. The block sustains one item per
// clock while the result side does not stall: the back end does one
// read-modify-write of a single monitor entry, or one source decision, per cycle.
// An item transferred in waits at the head of the queue and then loads the
// result register, which holds the result until its transfer is taken.
// Input stall rises only when the queue is full, which requires the result
// side to have stalled. Write configuration only while no item is in flight.
module redundant_link_alive_supervisor #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  rlas_pkg::item_t                       item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output rlas_pkg::result_t                     result,
  input  logic                                  cfg_write,
  input  logic [rlas_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rlas_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rlas_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_not_empty;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_timeout_ms     <= RST_STALE_TIMEOUT;
      cfg.control_frame_length <= RST_CONTROL_LEN;
      cfg.service_frame_length <= RST_SERVICE_LEN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STALE_TIMEOUT: cfg.stale_timeout_ms     <= cfg_data;
        REG_CONTROL_LEN:   cfg.control_frame_length <= cfg_data[6:0];
        REG_SERVICE_LEN:   cfg.service_frame_length <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Classify the incoming transfer.
  rlas_front u_front (
    .item       (item),
    .item_valid (item_valid),
    .cfg        (cfg),
    .queue_full (queue_full),
    .item_stall (item_stall),
    .push       (push),
    .cmd        (front_cmd)
  );

  // Decouple the two sides so each can stall on its own.
  rlas_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_data (head_cmd)
  );

  // Apply commands to the monitors and the source selector.
  rlas_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (head_cmd),
    .cmd_valid    (queue_not_empty),
    .result_stall (result_stall),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  // The queue fills only behind a result that is held back.
  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && $past(result_stall)))
    else $error("input stalled without result backpressure");

  // A service request is only offered once accepted.
  a_service_implies_accept: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.service_ready) |-> (result.accepted && result.recognized))
    else $error("service offered for a frame that was not accepted");

  // A discontinuity flag always matches a duplicate or gap status.
  a_disc_matches_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.discontinuity) |->
      (result.alive_status == ST_DUP || result.alive_status == ST_GAP))
    else $error("discontinuity without duplicate or gap status");

  // A duplicate is never accepted.
  a_dup_not_accepted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.alive_status == ST_DUP) |-> !result.accepted)
    else $error("duplicate frame reported as accepted");

endmodule
